>>> rtl/snf_pkg.sv
// Shared constants and types for the fractal simplex noise block.
`default_nettype none

package snf_pkg;

   // Build-time limits
   localparam int MAX_OCTAVES     = 8;
   localparam int COORD_FRAC_BITS = 16;

   // Port widths
   localparam int XY_W       = 32;
   localparam int NOISE_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int OCTCFG_W   = 4;
   localparam int PERS_W     = 17;
   localparam int LAC_W      = 16;
   localparam int SEED_W     = 64;
   localparam int FREQ_W     = 32;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OCTAVES = 2'd0,
      CSR_PERSIST = 2'd1,
      CSR_LACUN   = 2'd2,
      CSR_SEED    = 2'd3
   } csr_index_type;

   // Reset values of the registers
   localparam logic [OCTCFG_W-1:0] OCTAVES_RST = 4'd4;
   localparam logic [PERS_W-1:0]   PERSIST_RST = 17'd32768;
   localparam logic [LAC_W-1:0]    LACUN_RST   = 16'd8192;

   // Shuffle generator
   localparam logic [63:0] LCG_MUL  = 64'h5851F42D4C957F2D;
   localparam logic [63:0] LCG_ADD  = 64'h14057B7EF767814F;
   localparam logic [63:0] LCG_BIAS = 64'd31;

   // Simplex skew / unskew in Q16
   localparam logic [14:0] SKEW_Q16   = 15'd23988;
   localparam logic [13:0] UNSKEW_Q16 = 14'd13849;
   localparam logic [7:0]  OCT_GAIN   = 8'd70;
   localparam int          CORNER_MAX = 46340;   // largest offset with d^2 below 2^31

   // Derived internal widths
   localparam int SCALE_SHIFT = COORD_FRAC_BITS - 4;
   localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
   localparam int SC_W        = 40;              // scaled coordinate, Q.16
   localparam int S_W         = SC_W + 1;        // skew term
   localparam int I_W         = SC_W + 2 - 16;   // cell index
   localparam int T_W         = I_W + 16;        // unskew term
   localparam int D_W         = 44;              // corner offsets
   localparam int SUM_W       = 33;              // sum of three corners
   localparam int VAL_W       = 24;              // octave value
   localparam int AMP_W       = 17 + MAX_OCTAVES;
   localparam int TOT_W       = AMP_W + $clog2(MAX_OCTAVES + 1);
   localparam int ACC_W       = VAL_W + AMP_W + $clog2(MAX_OCTAVES + 1);
   localparam int DEN_W       = TOT_W + 1;
   localparam int NUM_W       = 64;
   localparam int DIVC_W      = $clog2(NUM_W);

endpackage

`default_nettype wire

>>> rtl/snf_channels.sv
// Request and response channel interfaces of the noise block.
`default_nettype none

interface snf_req_if import snf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [XY_W-1:0] x_coord;
   logic signed [XY_W-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface snf_rsp_if import snf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

>>> rtl/simplex_noise_2d_fractal_top.sv
// Fractal 2D simplex noise: sequencer, permutation memory and shared divider.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    x_coord, y_coord (s32, Q16.16)
//   rsp_chan  out  valid/ready    noise_value (s16, Q1.15)
//   csr_*     in   csr_we         csr_index, csr_wdata (64b)
//
// Each octave walks the permutation memory six times via one registered
// read port and runs the three corners through one shared multiplier chain;
// the 64-step restoring divider does the final normalization.
// A seed change (and the first sample after reset) first rebuilds the table:
// an identity fill of all 256 entries, three warm-up LCG steps, then per
// entry one LCG step, a modulo division and a swap.
// Reset is synchronous; the table holds no valid data until the first build.
// The result sits in an output register, so a new request is taken while a
// stalled response waits.
`default_nettype none

module simplex_noise_2d_fractal_top import snf_pkg::*; (
   input  wire                     clock,
   input  wire                     reset,
   snf_req_if.sink                 req_chan,
   snf_rsp_if.source               rsp_chan,
   input  wire                     csr_we,
   input  wire [CSR_IDX_W-1:0]     csr_index,
   input  wire [CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE, ST_INIT,
      ST_L0, ST_L1, ST_L2, ST_L3,
      ST_MODS, ST_DIV, ST_MODF, ST_SW1, ST_SW2, ST_SW3,
      ST_SCX, ST_SCY, ST_SCY2, ST_SKEW, ST_CELL, ST_UNSK, ST_OFF, ST_OFF2,
      ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
      ST_CSQX, ST_CSQY, ST_CT, ST_CT2, ST_CT4, ST_CMUL,
      ST_VAL, ST_ACC, ST_FREQ, ST_AMP,
      ST_DIVS, ST_RES, ST_OUT
   } state_type;

   localparam logic signed [64:0] SC_LIMIT = (65'sd1 <<< (SC_W - 1)) - 65'sd1;
   localparam logic [63:0]        ONE_Q16  = 64'd65536;

   // configuration
   logic [OCTCFG_W-1:0] octave_count_ff;
   logic [PERS_W-1:0]   persistence_ff;
   logic [LAC_W-1:0]    lacunarity_ff;
   logic [SEED_W-1:0]   seed_ff;
   logic [SEED_W-1:0]   built_seed_ff;
   logic                table_valid_ff;

   state_type           state_ff;

   // permutation memory
   logic [7:0]          perm_ff [256];
   logic [7:0]          mem_rd_ff;
   logic [7:0]          mem_addr;
   logic [7:0]          mem_wdata;
   logic                mem_we;

   // table build
   logic [7:0]          cnt_ff;
   logic [1:0]          lcg_left_ff;
   logic [63:0]         lcg_ff;
   logic [63:0]         prod_ff;
   logic [31:0]         hi_ff;
   logic [7:0]          r_ff;
   logic [7:0]          ar_ff;
   logic [7:0]          ak_ff;

   // divider
   logic [NUM_W-1:0]    div_num_ff;
   logic [DEN_W-1:0]    div_rem_ff;
   logic [DEN_W-1:0]    div_den_ff;
   logic [DIVC_W-1:0]   div_cnt_ff;
   logic                div_final_ff;
   logic                neg_ff;

   // sample
   logic signed [XY_W-1:0]  x_ff, y_ff;
   logic [FREQ_W-1:0]       freq_ff;
   logic [AMP_W-1:0]        amp_ff;
   logic [TOT_W-1:0]        total_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [OCT_W-1:0]        oct_ff, oct_lim_ff;
   logic signed [64:0]      mulc_ff;
   logic signed [SC_W-1:0]  sx_ff, sy_ff;
   logic signed [S_W-1:0]   skew_ff;
   logic signed [I_W-1:0]   i_ff, j_ff;
   logic signed [T_W-1:0]   t_ff;
   logic signed [D_W-1:0]   x0_ff, y0_ff;
   logic                    i1_ff;
   logic signed [D_W-1:0]   dx_ff [3];
   logic signed [D_W-1:0]   dy_ff [3];
   logic [7:0]              p0_ff, p1_ff, p2_ff;
   logic [7:0]              hash_ff [3];
   logic [1:0]              c_ff;
   logic                    near_ff;
   logic [31:0]             sqx_ff, sqy_ff;
   logic [15:0]             tq_ff;
   logic signed [19:0]      g_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic signed [NOISE_W-1:0] res_ff;

   // response register
   logic                      rsp_valid_ff;
   logic signed [NOISE_W-1:0] rsp_data_ff;

   // combinational helpers
   logic [OCT_W-1:0]        oct_lim_c;
   logic [8:0]              n_c;
   logic [7:0]              r_c;
   logic [63:0]             lcg_bias_c;
   logic signed [D_W-1:0]   x0_c, y0_c;
   logic signed [D_W-1:0]   cdx, cdy;
   logic signed [17:0]      dx18, dy18, gu, gv;
   logic [15:0]             adx, ady;
   logic                    dx_near, dy_near;
   logic signed [33:0]      tt_c;
   logic signed [19:0]      grad_c;
   logic [2:0]              h_c;
   logic [DEN_W:0]          rem_sh_c;
   logic [ACC_W-1:0]        acc_mag_c;
   logic [47:0]             freq_prod_c;
   logic [AMP_W+PERS_W-1:0] amp_prod_c;
   logic signed [56:0]      skew_prod_c;
   logic signed [40:0]      val_prod_c;
   logic signed [36:0]      corner_c;

   function automatic logic signed [SC_W-1:0] sat_scaled(input logic signed [64:0] p);
      logic signed [64:0] sh;
      sh = p >>> SCALE_SHIFT;
      if (sh > SC_LIMIT)       return SC_LIMIT[SC_W-1:0];
      else if (sh < -SC_LIMIT) return -SC_LIMIT[SC_W-1:0];
      else                     return sh[SC_W-1:0];
   endfunction

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.noise_value = rsp_data_ff;

   // octave count clamp
   always_comb begin
      if (octave_count_ff == '0)
         oct_lim_c = OCT_W'(1);
      else if (32'(octave_count_ff) > 32'(MAX_OCTAVES))
         oct_lim_c = OCT_W'(MAX_OCTAVES);
      else
         oct_lim_c = OCT_W'(octave_count_ff);
   end

   // shuffle index: floor modulo of the biased LCG word
   assign n_c        = {1'b0, cnt_ff} + 9'd1;
   assign lcg_bias_c = lcg_ff + LCG_BIAS;
   always_comb begin
      if (!neg_ff)
         r_c = div_rem_ff[7:0];
      else if (div_rem_ff == '0)
         r_c = 8'd0;
      else
         r_c = 8'(n_c - 9'(div_rem_ff));
   end

   // cell origin offsets
   assign x0_c = D_W'(sx_ff) - (D_W'(i_ff) <<< 16) + D_W'(t_ff);
   assign y0_c = D_W'(sy_ff) - (D_W'(j_ff) <<< 16) + D_W'(t_ff);

   // corner under work
   assign cdx     = dx_ff[c_ff];
   assign cdy     = dy_ff[c_ff];
   assign dx_near = (cdx >= -D_W'(CORNER_MAX)) && (cdx <= D_W'(CORNER_MAX));
   assign dy_near = (cdy >= -D_W'(CORNER_MAX)) && (cdy <= D_W'(CORNER_MAX));
   assign dx18    = cdx[17:0];
   assign dy18    = cdy[17:0];
   assign adx     = dx18[17] ? 16'(-dx18) : dx18[15:0];
   assign ady     = dy18[17] ? 16'(-dy18) : dy18[15:0];
   assign tt_c    = 34'sh80000000 - $signed({2'b00, sqx_ff}) - $signed({2'b00, sqy_ff});
   assign h_c     = hash_ff[c_ff][2:0];
   assign gu      = h_c[2] ? dy18 : dx18;
   assign gv      = h_c[2] ? dx18 : dy18;
   assign grad_c  = (h_c[0] ? -20'(gu) : 20'(gu)) + (h_c[1] ? -(20'(gv) <<< 1) : (20'(gv) <<< 1));
   assign corner_c = $signed({1'b0, tq_ff}) * g_ff;

   // wide products, each feeding one register
   assign skew_prod_c = (57'(sx_ff) + 57'(sy_ff)) * $signed({42'd0, SKEW_Q16});
   assign val_prod_c  = 41'(sum_ff) * $signed({33'd0, OCT_GAIN});
   assign freq_prod_c = 48'(freq_ff) * 48'(lacunarity_ff);
   assign amp_prod_c  = (AMP_W+PERS_W)'(amp_ff) * (AMP_W+PERS_W)'(persistence_ff);
   assign acc_mag_c   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   // restoring divider step
   assign rem_sh_c = {div_rem_ff, div_num_ff[NUM_W-1]};

   // memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = 8'd0;
      mem_wdata = 8'd0;
      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = cnt_ff;
         end
         ST_MODF: mem_addr = r_c;
         ST_SW1:  mem_addr = cnt_ff;
         ST_SW2: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = ar_ff;
         end
         ST_SW3: begin
            mem_we    = 1'b1;
            mem_addr  = r_ff;
            mem_wdata = ak_ff;
         end
         ST_OFF2: mem_addr = j_ff[7:0];
         ST_H1:   mem_addr = j_ff[7:0] + {7'd0, ~i1_ff};
         ST_H2:   mem_addr = j_ff[7:0] + 8'd1;
         ST_H3:   mem_addr = i_ff[7:0] + p0_ff;
         ST_H4:   mem_addr = i_ff[7:0] + {7'd0, i1_ff} + p1_ff;
         ST_H5:   mem_addr = i_ff[7:0] + 8'd1 + p2_ff;
         default: mem_addr = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         perm_ff[mem_addr] <= mem_wdata;
      mem_rd_ff <= perm_ff[mem_addr];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= OCTAVES_RST;
         persistence_ff  <= PERSIST_RST;
         lacunarity_ff   <= LACUN_RST;
         seed_ff         <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OCTAVES: octave_count_ff <= csr_wdata[OCTCFG_W-1:0];
            CSR_PERSIST: persistence_ff  <= csr_wdata[PERS_W-1:0];
            CSR_LACUN:   lacunarity_ff   <= csr_wdata[LAC_W-1:0];
            CSR_SEED:    seed_ff         <= csr_wdata[SEED_W-1:0];
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         table_valid_ff <= 1'b0;
         built_seed_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // load a new result when the slot is free or drains this cycle
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_chan.ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_chan.ready)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  x_ff       <= req_chan.x_coord;
                  y_ff       <= req_chan.y_coord;
                  freq_ff    <= FREQ_W'(4096);
                  amp_ff     <= AMP_W'(ONE_Q16);
                  total_ff   <= '0;
                  acc_ff     <= '0;
                  oct_ff     <= '0;
                  oct_lim_ff <= oct_lim_c;
                  cnt_ff     <= 8'd0;
                  if (!table_valid_ff || built_seed_ff != seed_ff)
                     state_ff <= ST_INIT;
                  else
                     state_ff <= ST_SCX;
               end
            end

            // identity fill, then shuffle from the top entry down
            ST_INIT: begin
               if (cnt_ff == 8'd255) begin
                  lcg_ff      <= seed_ff;
                  lcg_left_ff <= 2'd3;
                  state_ff    <= ST_L0;
               end else begin
                  cnt_ff <= cnt_ff + 8'd1;
               end
            end

            // 64-bit LCG step from 32x32 partial products
            ST_L0: begin
               prod_ff  <= 64'(lcg_ff[31:0]) * 64'(LCG_MUL[31:0]);
               state_ff <= ST_L1;
            end
            ST_L1: begin
               hi_ff    <= 32'(64'(lcg_ff[63:32]) * 64'(LCG_MUL[31:0]));
               state_ff <= ST_L2;
            end
            ST_L2: begin
               hi_ff    <= hi_ff + 32'(64'(lcg_ff[31:0]) * 64'(LCG_MUL[63:32]));
               state_ff <= ST_L3;
            end
            ST_L3: begin
               lcg_ff <= prod_ff + {hi_ff, 32'd0} + LCG_ADD;
               if (lcg_left_ff != 2'd0) begin
                  lcg_left_ff <= lcg_left_ff - 2'd1;
                  state_ff    <= ST_L0;
               end else begin
                  state_ff <= ST_MODS;
               end
            end

            ST_MODS: begin
               neg_ff       <= lcg_bias_c[63];
               div_num_ff   <= lcg_bias_c[63] ? -lcg_bias_c : lcg_bias_c;
               div_den_ff   <= DEN_W'(n_c);
               div_rem_ff   <= '0;
               div_cnt_ff   <= '0;
               div_final_ff <= 1'b0;
               state_ff     <= ST_DIV;
            end

            ST_DIV: begin
               if (rem_sh_c >= {1'b0, div_den_ff}) begin
                  div_rem_ff <= DEN_W'(rem_sh_c - {1'b0, div_den_ff});
                  div_num_ff <= {div_num_ff[NUM_W-2:0], 1'b1};
               end else begin
                  div_rem_ff <= rem_sh_c[DEN_W-1:0];
                  div_num_ff <= {div_num_ff[NUM_W-2:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + DIVC_W'(1);
               if (div_cnt_ff == DIVC_W'(NUM_W - 1))
                  state_ff <= div_final_ff ? ST_RES : ST_MODF;
            end

            // swap entries k and r
            ST_MODF: begin
               r_ff     <= r_c;
               state_ff <= ST_SW1;
            end
            ST_SW1: begin
               ar_ff    <= mem_rd_ff;
               state_ff <= ST_SW2;
            end
            ST_SW2: begin
               ak_ff    <= mem_rd_ff;
               state_ff <= ST_SW3;
            end
            ST_SW3: begin
               if (cnt_ff == 8'd0) begin
                  built_seed_ff  <= seed_ff;
                  table_valid_ff <= 1'b1;
                  state_ff       <= ST_SCX;
               end else begin
                  cnt_ff      <= cnt_ff - 8'd1;
                  lcg_left_ff <= 2'd0;
                  state_ff    <= ST_L0;
               end
            end

            // scale point by frequency
            ST_SCX: begin
               mulc_ff  <= 65'(x_ff) * $signed({33'd0, freq_ff});
               state_ff <= ST_SCY;
            end
            ST_SCY: begin
               sx_ff    <= sat_scaled(mulc_ff);
               mulc_ff  <= 65'(y_ff) * $signed({33'd0, freq_ff});
               state_ff <= ST_SCY2;
            end
            ST_SCY2: begin
               sy_ff    <= sat_scaled(mulc_ff);
               state_ff <= ST_SKEW;
            end

            // simplex cell and offsets
            ST_SKEW: begin
               skew_ff  <= skew_prod_c[56:16];
               state_ff <= ST_CELL;
            end
            ST_CELL: begin
               i_ff     <= I_W'(((SC_W+2)'(sx_ff) + (SC_W+2)'(skew_ff)) >>> 16);
               j_ff     <= I_W'(((SC_W+2)'(sy_ff) + (SC_W+2)'(skew_ff)) >>> 16);
               state_ff <= ST_UNSK;
            end
            ST_UNSK: begin
               t_ff     <= (T_W'(i_ff) + T_W'(j_ff)) * $signed({28'd0, UNSKEW_Q16});
               state_ff <= ST_OFF;
            end
            ST_OFF: begin
               x0_ff    <= x0_c;
               y0_ff    <= y0_c;
               i1_ff    <= (x0_c > y0_c);
               state_ff <= ST_OFF2;
            end
            ST_OFF2: begin
               dx_ff[0] <= x0_ff;
               dy_ff[0] <= y0_ff;
               dx_ff[1] <= x0_ff - (i1_ff ? D_W'(ONE_Q16) : '0) + D_W'(UNSKEW_Q16);
               dy_ff[1] <= y0_ff - (i1_ff ? '0 : D_W'(ONE_Q16)) + D_W'(UNSKEW_Q16);
               dx_ff[2] <= x0_ff - D_W'(ONE_Q16) + (D_W'(UNSKEW_Q16) <<< 1);
               dy_ff[2] <= y0_ff - D_W'(ONE_Q16) + (D_W'(UNSKEW_Q16) <<< 1);
               sum_ff   <= '0;
               c_ff     <= 2'd0;
               state_ff <= ST_H1;
            end

            // hash lookups, one read per cycle
            ST_H1: begin p0_ff      <= mem_rd_ff; state_ff <= ST_H2; end
            ST_H2: begin p1_ff      <= mem_rd_ff; state_ff <= ST_H3; end
            ST_H3: begin p2_ff      <= mem_rd_ff; state_ff <= ST_H4; end
            ST_H4: begin hash_ff[0] <= mem_rd_ff; state_ff <= ST_H5; end
            ST_H5: begin hash_ff[1] <= mem_rd_ff; state_ff <= ST_H6; end
            ST_H6: begin hash_ff[2] <= mem_rd_ff; state_ff <= ST_CSQX; end

            // corner falloff and gradient
            ST_CSQX: begin
               near_ff  <= dx_near && dy_near;
               sqx_ff   <= 32'(adx) * 32'(adx);
               state_ff <= ST_CSQY;
            end
            ST_CSQY: begin
               sqy_ff   <= 32'(ady) * 32'(ady);
               state_ff <= ST_CT;
            end
            ST_CT: begin
               tq_ff    <= (near_ff && tt_c > 0) ? tt_c[31:16] : 16'd0;
               g_ff     <= grad_c;
               state_ff <= ST_CT2;
            end
            ST_CT2: begin
               tq_ff    <= 16'((32'(tq_ff) * 32'(tq_ff)) >> 16);
               state_ff <= ST_CT4;
            end
            ST_CT4: begin
               tq_ff    <= 16'((32'(tq_ff) * 32'(tq_ff)) >> 16);
               state_ff <= ST_CMUL;
            end
            ST_CMUL: begin
               sum_ff <= sum_ff + SUM_W'(corner_c);
               if (c_ff == 2'd2) begin
                  state_ff <= ST_VAL;
               end else begin
                  c_ff     <= c_ff + 2'd1;
                  state_ff <= ST_CSQX;
               end
            end

            // octave weighting
            ST_VAL: begin
               val_ff   <= val_prod_c[VAL_W+15:16];
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff   <= acc_ff + ACC_W'(val_ff) * ACC_W'($signed({1'b0, amp_ff}));
               total_ff <= total_ff + TOT_W'(amp_ff);
               state_ff <= ST_FREQ;
            end
            ST_FREQ: begin
               if (freq_prod_c[47:44] != 4'd0)
                  freq_ff <= '1;
               else
                  freq_ff <= freq_prod_c[43:12];
               state_ff <= ST_AMP;
            end
            ST_AMP: begin
               amp_ff <= AMP_W'(amp_prod_c >> 16);
               oct_ff <= oct_ff + OCT_W'(1);
               if (oct_ff + OCT_W'(1) == oct_lim_ff)
                  state_ff <= ST_DIVS;
               else
                  state_ff <= ST_SCX;
            end

            // normalize: acc / (2 * total), toward zero
            ST_DIVS: begin
               neg_ff       <= acc_ff[ACC_W-1];
               div_num_ff   <= NUM_W'(acc_mag_c);
               div_den_ff   <= {total_ff, 1'b0};
               div_rem_ff   <= '0;
               div_cnt_ff   <= '0;
               div_final_ff <= 1'b1;
               state_ff     <= ST_DIV;
            end
            ST_RES: begin
               if (neg_ff) begin
                  if (div_num_ff > NUM_W'(32768))
                     res_ff <= -16'sd32768;
                  else
                     res_ff <= -$signed(div_num_ff[NOISE_W-1:0]);
               end else begin
                  if (div_num_ff > NUM_W'(32767))
                     res_ff <= 16'sd32767;
                  else
                     res_ff <= $signed(div_num_ff[NOISE_W-1:0]);
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_data_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> verif/simplex_noise_2d_fractal_top_tb.sv
// Self-checking testbench for the fractal 2D simplex noise block.
`timescale 1ns / 1ps

import snf_pkg::*;

class noise_scoreboard;
   logic [7:0]        perm[256];
   logic [63:0]       perm_seed;
   bit                perm_ok;
   logic [3:0]        octaves;
   logic [16:0]       persist;
   logic [15:0]       lacun;
   logic [63:0]       seed;
   logic signed [15:0] expected_q[$];
   int                errors;

   function new();
      perm_seed = '0;
      perm_ok   = 1'b0;
      octaves   = OCTAVES_RST;
      persist   = PERSIST_RST;
      lacun     = LACUN_RST;
      seed      = '0;
      errors    = 0;
   endfunction

   function void write_reg(csr_index_type idx, logic [63:0] data);
      case (idx)
         CSR_OCTAVES: octaves = data[3:0];
         CSR_PERSIST: persist = data[16:0];
         CSR_LACUN:   lacun   = data[15:0];
         CSR_SEED:    seed    = data;
         default: ;
      endcase
   endfunction

   // LCG shuffle, floor modulo on the signed draw
   function void shuffle_perm();
      logic [7:0]        pool[256];
      longint unsigned   s, v, n, r, rem;
      for (int k = 0; k < 256; k++) pool[k] = k[7:0];
      s = seed;
      for (int k = 0; k < 3; k++) s = s * LCG_MUL + LCG_ADD;
      for (int k = 255; k >= 0; k--) begin
         n = k + 1;
         s = s * LCG_MUL + LCG_ADD;
         v = s + LCG_BIAS;
         if (!v[63]) begin
            r = v % n;
         end else begin
            rem = ((~v) + 1) % n;
            r = (rem == 0) ? 0 : n - rem;
         end
         perm[k] = pool[r];
         pool[r] = pool[k];
      end
      perm_seed = seed;
      perm_ok   = 1'b1;
   endfunction

   function longint grad_dot(int h, longint dx, longint dy);
      longint u, v;
      h = h & 7;
      u = (h < 4) ? dx : dy;
      v = (h < 4) ? dy : dx;
      return ((h & 1) ? -u : u) + ((h & 2) ? -2 * v : 2 * v);
   endfunction

   function longint corner_term(int h, longint dx, longint dy);
      longint t;
      t = 64'sd2147483648 - dx * dx - dy * dy;
      if (t <= 0) return 0;
      t = t >>> 16;
      t = (t * t) >>> 16;
      t = (t * t) >>> 16;
      return t * grad_dot(h, dx, dy);
   endfunction

   function longint octave_noise(longint x, longint y);
      longint skew, unskew, s, i, j, t, x0, y0, x1, y1, x2, y2, total;
      int     ii, jj, i1, j1, h0, h1, h2;
      skew   = longint'(SKEW_Q16);
      unskew = longint'(UNSKEW_Q16);
      s  = ((x + y) * skew) >>> 16;
      i  = (x + s) >>> 16;
      j  = (y + s) >>> 16;
      t  = (i + j) * unskew;
      x0 = x - (i * 65536 - t);
      y0 = y - (j * 65536 - t);
      ii = int'(i & 255);
      jj = int'(j & 255);
      i1 = (x0 > y0) ? 1 : 0;
      j1 = 1 - i1;
      x1 = x0 - i1 * 65536 + unskew;
      y1 = y0 - j1 * 65536 + unskew;
      x2 = x0 - 65536 + 2 * unskew;
      y2 = y0 - 65536 + 2 * unskew;
      h0 = perm[(ii + perm[jj]) & 255];
      h1 = perm[(ii + i1 + perm[(jj + j1) & 255]) & 255];
      h2 = perm[(ii + 1 + perm[(jj + 1) & 255]) & 255];
      total = corner_term(h0, x0, y0) + corner_term(h1, x1, y1) + corner_term(h2, x2, y2);
      return (70 * total) >>> 16;
   endfunction

   function longint scaled(longint c, longint unsigned f);
      longint v;
      v = (c * longint'(f)) >>> SCALE_SHIFT;
      if (v > 64'sd549755813887) v = 64'sd549755813887;
      if (v < -64'sd549755813887) v = -64'sd549755813887;
      return v;
   endfunction

   function void note_sample(logic signed [31:0] x, logic signed [31:0] y);
      longint unsigned freq, amp, amp_sum, count;
      longint          acc, val, res, xs, ys;
      if (!perm_ok || perm_seed != seed) shuffle_perm();
      count = octaves;
      if (count < 1) count = 1;
      if (count > MAX_OCTAVES) count = MAX_OCTAVES;
      freq = 4096; amp = 65536; amp_sum = 0; acc = 0;
      xs = x; ys = y;
      for (int k = 0; k < count; k++) begin
         val = octave_noise(scaled(xs, freq), scaled(ys, freq));
         acc += val * longint'(amp);
         amp_sum += amp;
         freq = (freq * lacun) >> 12;
         if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
         amp = (amp * persist) >> 16;
      end
      res = acc / longint'(2 * amp_sum);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      expected_q.push_back(res[15:0]);
   endfunction

   function void check_noise(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected noise_value %0d", $time, got);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
         $display("%0t: noise_value expected %0d actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module simplex_noise_2d_fractal_top_tb;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // sender gap / receiver stall odds, in percent per cycle
   int idle_pct  = 0;
   int stall_pct = 0;

   noise_scoreboard sb;

   snf_req_if req_bus ();
   snf_rsp_if rsp_bus ();

   simplex_noise_2d_fractal_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop well past the slowest legal run (rebuilds plus 8-octave samples)
   initial begin
      #6_000_000;
      $display("Verification failed");
      $finish;
   end

   // receiver: random back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // monitor: predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_sample(req_bus.x_coord, req_bus.y_coord);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_noise(rsp_bus.noise_value);
      end
   end

   // one request transfer, with random lead-in gaps
   task automatic send_sample(logic [31:0] x, logic [31:0] y);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.x_coord <= x;
      req_bus.y_coord <= y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold the sender off until every predicted response has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_q.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [63:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0: return $urandom;                                    // anywhere
         1: return $urandom_range(32'h0010_0000) - 32'h0008_0000; // within +-8.0
         2: return {16'($urandom_range(65535)), 16'h0000} + 32'($urandom_range(2)) - 32'd1;
         default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(15)
                                           : 32'h8000_0000 + $urandom_range(15);
      endcase
   endfunction

   initial begin
      int           oct;
      logic [63:0]  sv;
      sb = new();
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_OCTAVES;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.x_coord <= '0;
      req_bus.y_coord <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config, first use forces a table build from seed zero
      send_sample(32'h0000_0000, 32'h0000_0000);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h0001_0000, 32'h0002_0000);   // lattice point
      send_sample(32'h0000_8000, 32'hFFFF_8000);
      drain();

      // zero octaves acts as one; top lacunarity drives frequency saturation
      csr_write(CSR_OCTAVES, 64'hFFFF_FFFF_FFFF_FFF0);
      csr_write(CSR_LACUN, 64'd65535);
      csr_write(CSR_PERSIST, 64'd65536);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      drain();
      csr_write(CSR_OCTAVES, 64'd8);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF);   // scaled point clamps
      send_sample(32'h0003_4567, 32'hFFFC_1234);
      drain();

      // octave count above the limit, zero lacunarity and persistence, new seed
      csr_write(CSR_OCTAVES, 64'd15);
      csr_write(CSR_LACUN, 64'd0);
      csr_write(CSR_PERSIST, 64'd0);
      csr_write(CSR_SEED, 64'h8000_0000_0000_0000);
      send_sample(32'h0001_2345, 32'h0006_789A);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001);
      drain();
      csr_write(CSR_SEED, 64'h7FFF_FFFF_FFFF_FFFF);
      csr_write(CSR_OCTAVES, 64'd1);
      send_sample(32'h1234_5678, 32'h8765_4321);
      drain();

      // random blocks, one config setting each, idling style rotates
      for (int blk = 0; blk < 8; blk++) begin
         drain();
         case (blk % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         case ($urandom_range(9))
            0: oct = 0;
            1: oct = $urandom_range(15, 8);
            default: oct = $urandom_range(4, 1);
         endcase
         csr_write(CSR_OCTAVES, {$urandom, $urandom_range(15, 0) + ($urandom & 32'hFFFF_FFF0)}
                                & 64'hFFFF_FFFF_FFFF_FFF0 | oct);
         csr_write(CSR_PERSIST, $urandom_range(3) == 0 ? ($urandom_range(1) ? 65536 : 0)
                                                       : $urandom_range(65536));
         csr_write(CSR_LACUN, $urandom_range(3) == 0 ? ($urandom_range(1) ? 65535 : 0)
                                                     : $urandom_range(65535));
         // seed changes cost a full table rebuild, so not every block
         if (blk < 2 || $urandom_range(2) != 0) begin
            case ($urandom_range(4))
               0: sv = 64'hFFFF_FFFF_FFFF_FFFF;
               1: sv = 64'h0;
               default: sv = {$urandom, $urandom};
            endcase
            csr_write(CSR_SEED, sv);
         end
         for (int n = 0; n < 115; n++) begin
            // short bursts with no sender gaps inside gapped phases
            if (blk % 4 == 1 && n % 40 == 0) idle_pct = (idle_pct == 0) ? 46 : 0;
            send_sample(pick_coord(), pick_coord());
         end
      end

      drain();
      repeat (400) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
